>>> design/sefr_pkg.sv
// Shared types and constants for the STX/ETX frame receiver.
// Used by sefr_ctrl and stx_etx_frame_receiver; depends on nothing.
package sefr_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CNT_W     = AW + 1;

  // operation codes
  localparam logic [2:0] OP_BYTE      = 3'd0;
  localparam logic [2:0] OP_BYTE_ERR  = 3'd1;
  localparam logic [2:0] OP_RELEASE   = 3'd2;
  localparam logic [2:0] OP_ARM_WAIT  = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_CLEAR_RX  = 3'd5;
  localparam logic [2:0] OP_CLEAR_ACK = 3'd6;

  // configuration register indexes
  localparam logic [7:0] CFG_START = 8'd0;
  localparam logic [7:0] CFG_END   = 8'd1;
  localparam logic [7:0] CFG_ACK   = 8'd2;
  localparam logic [7:0] CFG_NACK  = 8'd3;

  localparam logic [7:0] START_RST = 8'd2;
  localparam logic [7:0] END_RST   = 8'd3;
  localparam logic [7:0] ACK_RST   = 8'd6;
  localparam logic [7:0] NACK_RST  = 8'd21;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2,
    PH_BLOCK = 2'd3
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] rx_phase;
    logic [8:0] frame_count;
    logic       command_ready;
    logic       waiting_data;
    logic       ack_flag;
    logic       nack_flag;
    logic [7:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
  } cfg_regs_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   count;
    logic               cmd_pending;
    logic               wait_armed;
    logic               ack_seen;
    logic               nack_seen;
  } status_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } wr_t;

endpackage

>>> design/stx_etx_frame_receiver.sv
// Top level of the STX/ETX frame receiver: input register, frame store,
// result register and configuration registers. Depends on sefr_pkg, sefr_ctrl.
//
// Usage:
//   in_valid/in_ready/in_data carry one item: a received byte, an errored
//   byte, or an application op (release, arm wait, read, clear receiver,
//   clear ack flags). Every item gives exactly one result on
//   out_valid/out_ready/out_data: the receiver status after the item, plus
//   the store byte for a read (zero otherwise or when read_index is past
//   the store).
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata write the start, end, ack and
//   nack codes (indexes 0..3, others ignored); cfg_ready is always high.
//   out_valid rises when the result register loads; one item per cycle while
//   out_ready is high. Each item is updated against state in one registered
//   pass and the store is read on the same edge that loads the result register.
//   Reset puts the receiver in waiting with count zero, all flags clear and
//   the codes at 2, 3, 6, 21; the frame store is not cleared.
//   When out_ready is low the result register holds and in_ready drops
//   once the input register is also occupied.
module stx_etx_frame_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sefr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sefr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic                    s1_v_r;
  sefr_pkg::in_item_t      s1_r;
  logic                    out_v_r;
  sefr_pkg::out_item_t     out_r;
  sefr_pkg::out_item_t     out_nxt;
  logic                    rv_en_r;
  logic                    rv_en_nxt;
  logic [7:0]              rd_q_r;
  sefr_pkg::cfg_regs_t     cfg_r;
  sefr_pkg::status_t       st_nxt;
  sefr_pkg::wr_t           wr;
  logic                    advance;
  logic                    step;
  logic [7:0]              mem [sefr_pkg::BUF_DEPTH];

  assign advance   = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || advance;
  assign step      = s1_v_r && advance;
  assign cfg_ready = 1'b1;

  sefr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .wr     (wr)
  );

  always_comb begin
    out_nxt               = '0;
    out_nxt.rx_phase      = st_nxt.phase;
    out_nxt.frame_count   = 9'(st_nxt.count);
    out_nxt.command_ready = st_nxt.cmd_pending;
    out_nxt.waiting_data  = st_nxt.wait_armed;
    out_nxt.ack_flag      = st_nxt.ack_seen;
    out_nxt.nack_flag     = st_nxt.nack_seen;
    rv_en_nxt = (s1_r.op == sefr_pkg::OP_READ) &&
                (32'(s1_r.read_index) < sefr_pkg::BUF_DEPTH);
  end

  always_comb begin
    out_data            = out_r;
    out_data.read_value = rv_en_r ? rd_q_r : 8'd0;
  end
  assign out_valid = out_v_r;

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (step) begin
      rd_q_r <= mem[sefr_pkg::AW'(s1_r.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r  <= in_valid;
      if (advance)  out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_r <= in_data;
    if (step) begin
      out_r   <= out_nxt;
      rv_en_r <= rv_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code <= sefr_pkg::START_RST;
      cfg_r.end_code   <= sefr_pkg::END_RST;
      cfg_r.ack_code   <= sefr_pkg::ACK_RST;
      cfg_r.nack_code  <= sefr_pkg::NACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sefr_pkg::CFG_START: cfg_r.start_code <= cfg_wdata;
        sefr_pkg::CFG_END:   cfg_r.end_code   <= cfg_wdata;
        sefr_pkg::CFG_ACK:   cfg_r.ack_code   <= cfg_wdata;
        sefr_pkg::CFG_NACK:  cfg_r.nack_code  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> design/sefr_ctrl.sv
// Receiver state: phase, byte count and sticky flags, with their update per item.
// Drives the frame store write. Depends on sefr_pkg.
module sefr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sefr_pkg::in_item_t  item,
  input  sefr_pkg::cfg_regs_t cfg,
  output sefr_pkg::status_t   st_nxt,
  output sefr_pkg::wr_t       wr
);

  sefr_pkg::status_t             st_r;
  sefr_pkg::phase_t              phase_nxt;
  logic [sefr_pkg::CNT_W-1:0]    count_nxt;
  sefr_pkg::phase_t              eff_phase;
  logic [sefr_pkg::CNT_W-1:0]    eff_count;
  logic                          full;
  logic                          room;
  logic                          is_byte;

  // a full buffer is cleared before the byte is looked at
  assign full      = st_r.count >= sefr_pkg::CNT_W'(sefr_pkg::BUF_DEPTH);
  assign eff_phase = full ? sefr_pkg::PH_WAIT : st_r.phase;
  assign eff_count = full ? '0 : st_r.count;
  assign room      = eff_count < sefr_pkg::CNT_W'(sefr_pkg::BUF_DEPTH);
  assign is_byte   = step && (item.op == sefr_pkg::OP_BYTE);

  // next state: phase and count
  always_comb begin
    phase_nxt = st_r.phase;
    count_nxt = st_r.count;
    if (step) begin
      case (item.op)
        sefr_pkg::OP_BYTE: begin
          phase_nxt = eff_phase;
          count_nxt = eff_count;
          case (eff_phase)
            sefr_pkg::PH_WAIT: begin
              if (item.rx_byte == cfg.start_code && !st_r.cmd_pending) begin
                phase_nxt = sefr_pkg::PH_DATA;
                count_nxt = '0;
              end
            end
            sefr_pkg::PH_DATA: begin
              if (item.rx_byte == cfg.end_code) begin
                phase_nxt = sefr_pkg::PH_CHECK;
              end else if (room) begin
                count_nxt = eff_count + sefr_pkg::CNT_W'(1);
              end
            end
            sefr_pkg::PH_CHECK: begin
              if (room) begin
                count_nxt = eff_count + sefr_pkg::CNT_W'(1);
              end
              phase_nxt = sefr_pkg::PH_BLOCK;
            end
            default: begin
              if (!st_r.cmd_pending) begin
                phase_nxt = sefr_pkg::PH_WAIT;
                count_nxt = '0;
              end
            end
          endcase
        end
        sefr_pkg::OP_CLEAR_RX: begin
          phase_nxt = sefr_pkg::PH_WAIT;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // outputs: flags and store write
  always_comb begin
    st_nxt       = st_r;
    st_nxt.phase = phase_nxt;
    st_nxt.count = count_nxt;
    wr.en        = 1'b0;
    wr.addr      = eff_count[sefr_pkg::AW-1:0];
    wr.data      = item.rx_byte;
    if (step) begin
      case (item.op)
        sefr_pkg::OP_BYTE: begin
          case (eff_phase)
            sefr_pkg::PH_WAIT: begin
              if (item.rx_byte == cfg.ack_code)  st_nxt.ack_seen  = 1'b1;
              if (item.rx_byte == cfg.nack_code) st_nxt.nack_seen = 1'b1;
            end
            sefr_pkg::PH_DATA: begin
              wr.en = (item.rx_byte != cfg.end_code) && room;
            end
            sefr_pkg::PH_CHECK: begin
              wr.en = room;
              if (st_r.wait_armed) st_nxt.wait_armed  = 1'b0;
              else                 st_nxt.cmd_pending = 1'b1;
            end
            default: ;
          endcase
        end
        sefr_pkg::OP_RELEASE:  st_nxt.cmd_pending = 1'b0;
        sefr_pkg::OP_ARM_WAIT: st_nxt.wait_armed  = 1'b1;
        sefr_pkg::OP_CLEAR_ACK: begin
          st_nxt.ack_seen  = 1'b0;
          st_nxt.nack_seen = 1'b0;
        end
        default: ;
      endcase
    end
    // keep the write gated to real byte items
    wr.en = wr.en && is_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= sefr_pkg::PH_WAIT;
      st_r.count       <= '0;
      st_r.cmd_pending <= 1'b0;
      st_r.wait_armed  <= 1'b0;
      st_r.ack_seen    <= 1'b0;
      st_r.nack_seen   <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> tb/tb_stx_etx_frame_receiver.sv
// Self-checking testbench for stx_etx_frame_receiver: directed table, then framed random traffic.
// Holds its own model of the deframer and checks every result item in order.
// Depends on sefr_pkg and the stx_etx_frame_receiver RTL.
`timescale 1ns / 1ps

module tb_stx_etx_frame_receiver;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam logic [7:0] CFG_UNUSED  = 8'hA0;
  localparam int         PHASES      = 5;
  localparam int         PHASE_ITEMS = 280;
  localparam int         HOLD_CYCLES = 150;
  localparam int         STALL_LIMIT = 3000;

  typedef struct {
    sefr_pkg::in_item_t  item;
    bit                  typed;
    sefr_pkg::out_item_t want;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  sefr_pkg::in_item_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [7:0]          cfg_index = '0;
  logic [7:0]          cfg_wdata = '0;
  logic                in_ready;
  logic                out_valid;
  logic                cfg_ready;
  sefr_pkg::out_item_t out_data;

  // model state
  sefr_pkg::phase_t    rx_ph;
  logic [8:0]          rx_cnt;
  logic [7:0]          frame_mem [sefr_pkg::BUF_DEPTH];
  logic                cmd_hold;
  logic                wait_arm;
  logic                ack_hit;
  logic                nack_hit;
  sefr_pkg::cfg_regs_t codes;
  int                  written_hi;   // entries [0, written_hi) have been written

  sefr_pkg::out_item_t status_q [$];
  dir_row_t            script [$];
  int                  items_sent    = 0;
  int                  bad_results   = 0;
  int                  idle_cycles   = 0;
  bit                  steady        = 1'b0;
  bit                  hold_request  = 1'b0;

  stx_etx_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void store_rx(logic [7:0] b);
    if (rx_cnt < sefr_pkg::BUF_DEPTH) begin
      frame_mem[rx_cnt[sefr_pkg::AW-1:0]] = b;
      rx_cnt = rx_cnt + 9'd1;
      if (int'(rx_cnt) > written_hi) written_hi = int'(rx_cnt);
    end
  endfunction

  function automatic void take_rx(logic [7:0] b);
    // full store: start over and treat the byte as if waiting
    if (rx_cnt >= sefr_pkg::BUF_DEPTH) begin
      rx_ph  = sefr_pkg::PH_WAIT;
      rx_cnt = '0;
    end
    case (rx_ph)
      sefr_pkg::PH_WAIT: begin
        if (b == codes.ack_code)  ack_hit  = 1'b1;
        if (b == codes.nack_code) nack_hit = 1'b1;
        if (b == codes.start_code && !cmd_hold) begin
          rx_cnt = '0;
          rx_ph  = sefr_pkg::PH_DATA;
        end
      end
      sefr_pkg::PH_DATA: begin
        if (b == codes.end_code) rx_ph = sefr_pkg::PH_CHECK;
        else store_rx(b);
      end
      sefr_pkg::PH_CHECK: begin
        store_rx(b);
        if (!wait_arm) cmd_hold = 1'b1;
        else wait_arm = 1'b0;
        rx_ph = sefr_pkg::PH_BLOCK;
      end
      default: begin
        if (!cmd_hold) begin
          rx_ph  = sefr_pkg::PH_WAIT;
          rx_cnt = '0;
        end
      end
    endcase
  endfunction

  function automatic sefr_pkg::out_item_t step_receiver(sefr_pkg::in_item_t it);
    sefr_pkg::out_item_t r;
    r = '0;
    case (it.op)
      sefr_pkg::OP_BYTE:     take_rx(it.rx_byte);
      sefr_pkg::OP_RELEASE:  cmd_hold = 1'b0;
      sefr_pkg::OP_ARM_WAIT: wait_arm = 1'b1;
      sefr_pkg::OP_READ: begin
        if (it.read_index < sefr_pkg::BUF_DEPTH) r.read_value = frame_mem[it.read_index];
      end
      sefr_pkg::OP_CLEAR_RX: begin
        rx_ph  = sefr_pkg::PH_WAIT;
        rx_cnt = '0;
      end
      sefr_pkg::OP_CLEAR_ACK: begin
        ack_hit  = 1'b0;
        nack_hit = 1'b0;
      end
      default: ;
    endcase
    r.rx_phase      = rx_ph;
    r.frame_count   = rx_cnt;
    r.command_ready = cmd_hold;
    r.waiting_data  = wait_arm;
    r.ack_flag      = ack_hit;
    r.nack_flag     = nack_hit;
    return r;
  endfunction

  function automatic sefr_pkg::out_item_t st(sefr_pkg::phase_t ph, int cnt, bit cmd, bit wt,
                                             bit ak, bit nk, logic [7:0] rv);
    sefr_pkg::out_item_t r;
    r.rx_phase      = ph;
    r.frame_count   = cnt[8:0];
    r.command_ready = cmd;
    r.waiting_data  = wt;
    r.ack_flag      = ak;
    r.nack_flag     = nk;
    r.read_value    = rv;
    return r;
  endfunction

  function automatic dir_row_t row(logic [2:0] op, logic [7:0] b, logic [7:0] idx);
    dir_row_t d;
    d.item  = '{op: op, rx_byte: b, read_index: idx};
    d.typed = 1'b0;
    d.want  = '0;
    return d;
  endfunction

  function automatic dir_row_t row_typed(logic [2:0] op, logic [7:0] b, logic [7:0] idx,
                                         sefr_pkg::out_item_t want);
    dir_row_t d;
    d = row(op, b, idx);
    d.typed = 1'b1;
    d.want  = want;
    return d;
  endfunction

  function automatic string fmt(sefr_pkg::out_item_t s);
    return $sformatf("ph=%0d cnt=%0d cmd=%0b wait=%0b ack=%0b nack=%0b rd=%02h",
                     s.rx_phase, s.frame_count, s.command_ready, s.waiting_data,
                     s.ack_flag, s.nack_flag, s.read_value);
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic deliver(sefr_pkg::in_item_t it, bit typed, sefr_pkg::out_item_t want);
    sefr_pkg::out_item_t model;
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = step_receiver(it);
    status_q.push_back(typed ? want : model);
    items_sent++;
  endtask

  task automatic send(logic [2:0] op, logic [7:0] b);
    sefr_pkg::in_item_t it;
    it.op         = op;
    it.rx_byte    = b;
    it.read_index = 8'($urandom);
    // only written entries may be read back
    if (op == sefr_pkg::OP_READ) begin
      if (written_hi == 0) it.op = sefr_pkg::OP_CLEAR_ACK;
      else it.read_index = 8'($urandom_range(written_hi - 1, 0));
    end
    deliver(it, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return codes.start_code;
      1:       return codes.end_code;
      2:       return codes.ack_code;
      3:       return codes.nack_code;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(int len);
    logic [7:0] b;
    if (cmd_hold && $urandom_range(4) != 0) send(sefr_pkg::OP_RELEASE, 8'($urandom));
    if (rx_ph != sefr_pkg::PH_WAIT) begin
      if ($urandom_range(9) < 7) send(sefr_pkg::OP_CLEAR_RX, 8'($urandom));
      else send(sefr_pkg::OP_BYTE, 8'($urandom));
    end
    if ($urandom_range(3) == 0) send(sefr_pkg::OP_ARM_WAIT, 8'($urandom));
    if ($urandom_range(4) == 0)
      send(sefr_pkg::OP_BYTE, $urandom_range(1) ? codes.ack_code : codes.nack_code);
    send(sefr_pkg::OP_BYTE, codes.start_code);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == codes.end_code && $urandom_range(15) != 0) b = b ^ 8'h01;
      if ($urandom_range(24) == 0) send(sefr_pkg::OP_BYTE_ERR, codes.end_code);
      send(sefr_pkg::OP_BYTE, b);
    end
    send(sefr_pkg::OP_BYTE, codes.end_code);
    send(sefr_pkg::OP_BYTE, 8'($urandom));
    repeat ($urandom_range(3, 0)) send(sefr_pkg::OP_READ, 8'($urandom));
    if ($urandom_range(19) < 17) send(sefr_pkg::OP_RELEASE, 8'($urandom));
    if ($urandom_range(6) == 0) send(sefr_pkg::OP_CLEAR_ACK, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_code(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sefr_pkg::CFG_START: codes.start_code = val;
      sefr_pkg::CFG_END:   codes.end_code   = val;
      sefr_pkg::CFG_ACK:   codes.ack_code   = val;
      sefr_pkg::CFG_NACK:  codes.nack_code  = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(sefr_pkg::cfg_regs_t c, bit poke_unused);
    write_code(sefr_pkg::CFG_START, c.start_code);
    write_code(sefr_pkg::CFG_END,   c.end_code);
    write_code(sefr_pkg::CFG_ACK,   c.ack_code);
    write_code(sefr_pkg::CFG_NACK,  c.nack_code);
    if (poke_unused) write_code(CFG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    sefr_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result item: %s", fmt(out_data));
      end else begin
        want = status_q.pop_front();
        if (out_data.rx_phase !== want.rx_phase || out_data.frame_count !== want.frame_count ||
            out_data.command_ready !== want.command_ready ||
            out_data.waiting_data !== want.waiting_data ||
            out_data.ack_flag !== want.ack_flag || out_data.nack_flag !== want.nack_flag ||
            out_data.read_value !== want.read_value) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected %s, got %s", fmt(want), fmt(out_data));
        end
      end
    end
  end

  // no handshake on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_stx_etx_frame_receiver: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    sefr_pkg::cfg_regs_t plan;
    int                  phase_start;
    int                  seq;
    bit                  held;

    rx_ph      = sefr_pkg::PH_WAIT;
    rx_cnt     = '0;
    cmd_hold   = 1'b0;
    wait_arm   = 1'b0;
    ack_hit    = 1'b0;
    nack_hit   = 1'b0;
    written_hi = 0;
    codes      = '{sefr_pkg::START_RST, sefr_pkg::END_RST, sefr_pkg::ACK_RST,
                   sefr_pkg::NACK_RST};

    // default codes: STX 2, ETX 3, ACK 6, NACK 21
    script.push_back(row_typed(sefr_pkg::OP_CLEAR_ACK, 8'h00, 8'h00,
                               st(sefr_pkg::PH_WAIT, 0, 0, 0, 0, 0, 8'h00)));
    script.push_back(row_typed(sefr_pkg::OP_BYTE, sefr_pkg::ACK_RST, 8'hFF,
                               st(sefr_pkg::PH_WAIT, 0, 0, 0, 1, 0, 8'h00)));
    script.push_back(row_typed(sefr_pkg::OP_BYTE, sefr_pkg::NACK_RST, 8'h00,
                               st(sefr_pkg::PH_WAIT, 0, 0, 0, 1, 1, 8'h00)));
    script.push_back(row_typed(sefr_pkg::OP_BYTE_ERR, sefr_pkg::START_RST, 8'h00,
                               st(sefr_pkg::PH_WAIT, 0, 0, 0, 1, 1, 8'h00)));
    script.push_back(row(sefr_pkg::OP_BYTE, 8'hFF, 8'h00));
    script.push_back(row_typed(sefr_pkg::OP_BYTE, sefr_pkg::START_RST, 8'h00,
                               st(sefr_pkg::PH_DATA, 0, 0, 0, 1, 1, 8'h00)));
    script.push_back(row(sefr_pkg::OP_BYTE, 8'h00, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, 8'hFF, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::ACK_RST, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE_ERR, 8'h55, 8'h00));   // dropped mid-frame
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::END_RST, 8'h00));
    script.push_back(row_typed(sefr_pkg::OP_BYTE, 8'hA5, 8'h00,
                               st(sefr_pkg::PH_BLOCK, 4, 1, 0, 1, 1, 8'h00)));
    script.push_back(row(sefr_pkg::OP_READ, 8'hFF, 8'h00));
    script.push_back(row(sefr_pkg::OP_READ, 8'h00, 8'h03));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::START_RST, 8'h00));   // blocked, pending
    script.push_back(row(sefr_pkg::OP_CLEAR_RX, 8'h00, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::START_RST, 8'h00));   // STX refused
    script.push_back(row(sefr_pkg::OP_RELEASE, 8'h00, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::START_RST, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::END_RST, 8'h00));     // empty data
    script.push_back(row(sefr_pkg::OP_BYTE, 8'h3C, 8'h00));
    script.push_back(row(sefr_pkg::OP_RELEASE, 8'h00, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, 8'h07, 8'h00));       // blocked, nothing pending
    script.push_back(row(sefr_pkg::OP_ARM_WAIT, 8'h00, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::START_RST, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, sefr_pkg::END_RST, 8'h00));
    script.push_back(row(sefr_pkg::OP_BYTE, 8'h80, 8'h00));       // check byte only clears wait
    script.push_back(row(sefr_pkg::OP_CLEAR_ACK, 8'h00, 8'h00));
    script.push_back(row(OP_UNUSED, 8'hFF, 8'hFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) deliver(script[i].item, script[i].typed, script[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        1:       plan = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        2:       plan = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        3:       plan = '{sefr_pkg::START_RST, sefr_pkg::END_RST, sefr_pkg::ACK_RST,
                          sefr_pkg::NACK_RST};
        default: plan = $urandom;
      endcase
      set_codes(plan, ph == 0);
      steady      = (ph == 2);
      phase_start = items_sent;
      seq         = 0;
      held        = 1'b0;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        if ((ph == 0 || ph == 3) && !held && items_sent >= phase_start + 100) begin
          hold_request = 1'b1;
          held         = 1'b1;
        end
        if (ph == 4 && seq == 10) drain();
        if (seq == 2 && ph <= 1) begin
          send_frame(ph == 0 ? 270 : 200);
        end else if ($urandom_range(99) < 65) begin
          send_frame(($urandom_range(39) == 0) ? $urandom_range(300, 130) : $urandom_range(12, 0));
        end else begin
          repeat ($urandom_range(4, 1)) send(3'($urandom_range(7, 0)), pick_byte());
        end
        seq++;
      end
    end

    drain();
    steady = 1'b0;
    repeat (10) @(posedge clk);
    if (bad_results == 0)
      $display("tb_stx_etx_frame_receiver: clean");
    else
      $display("tb_stx_etx_frame_receiver: errors");
    $finish;
  end

endmodule
